>>> rtl/qbt_pkg.sv
`default_nettype none

package qbt_pkg;

	localparam int POS_BITS_DEF      = 16;
	localparam int KEYWORD_CHARS_DEF = 6;
	localparam int QUEUE_DEPTH       = 4;
	localparam int KW_COUNT          = 14;

	// Token kinds.
	localparam logic [5:0] K_EOF    = 6'd0;
	localparam logic [5:0] K_INT    = 6'd1;
	localparam logic [5:0] K_IDENT  = 6'd2;
	localparam logic [5:0] K_TRUE   = 6'd14;
	localparam logic [5:0] K_PLUS   = 6'd17;
	localparam logic [5:0] K_MINUS  = 6'd18;
	localparam logic [5:0] K_STAR   = 6'd19;
	localparam logic [5:0] K_SLASH  = 6'd20;
	localparam logic [5:0] K_PCT    = 6'd21;
	localparam logic [5:0] K_EQEQ   = 6'd22;
	localparam logic [5:0] K_NE     = 6'd23;
	localparam logic [5:0] K_LT     = 6'd24;
	localparam logic [5:0] K_LE     = 6'd25;
	localparam logic [5:0] K_GT     = 6'd26;
	localparam logic [5:0] K_GE     = 6'd27;
	localparam logic [5:0] K_ANDAND = 6'd28;
	localparam logic [5:0] K_OROR   = 6'd29;
	localparam logic [5:0] K_BANG   = 6'd30;
	localparam logic [5:0] K_AMP    = 6'd31;
	localparam logic [5:0] K_PIPE   = 6'd32;
	localparam logic [5:0] K_CARET  = 6'd33;
	localparam logic [5:0] K_LPAREN = 6'd34;
	localparam logic [5:0] K_RPAREN = 6'd35;
	localparam logic [5:0] K_COMMA  = 6'd36;
	localparam logic [5:0] K_SEMI   = 6'd37;
	localparam logic [5:0] K_ERROR  = 6'd38;

	// Error codes.
	localparam logic [1:0] E_NONE      = 2'd0;
	localparam logic [1:0] E_TOO_LARGE = 2'd1;
	localparam logic [1:0] E_EXPECT_EQ = 2'd2;
	localparam logic [1:0] E_UNEXPECTED = 2'd3;

	// Characters.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;
	localparam logic [7:0] CH_PIPE   = 8'h7C;

	// Keyword texts, first character in the lowest byte.
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'h0000_4D4F_5246, 48'h0045_5245_4857, 48'h0000_0054_454C,
		48'h0050_554F_5247, 48'h0000_0000_5942, 48'h0000_0047_4741,
		48'h0052_4544_524F, 48'h0054_494D_494C, 48'h0000_0044_4E41,
		48'h0000_0000_524F, 48'h0000_0054_4F4E, 48'h0000_4555_5254,
		48'h0045_534C_4146, 48'h454C_424D_5554
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd4, 3'd5, 3'd3, 3'd5, 3'd2, 3'd3, 3'd5,
		3'd5, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
	};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
		6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [63:0] value;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [1:0]  err;
		logic        last;
	} qbt_result_t;

endpackage

`default_nettype wire

>>> rtl/query_byte_tokenizer.sv
// Each accepted byte is tokenized in the cycle it is taken; its results are registered
// into a four-entry result queue that drives the output.
// Throughput is one item per cycle while the queue has room; an item that finishes a pending
// token and starts a one-byte token gives two results, which leave at one per cycle while m_tready is high.
// Input is ready while the queue has room for two results.
// Reset (arst_n low) returns the tokenizer to line 1, column 1 and empties the queue.
`default_nettype none

module query_byte_tokenizer import qbt_pkg::*; #(
	parameter int POS_BITS      = POS_BITS_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // in_byte
	input  wire logic         s_tuser,   // end_mark
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [119:0]      m_tdata,   // token_value, first line, first column,
	                                     // token_length, error_code, zero fill
	output logic [5:0]        m_tuser,   // token_kind
	output logic              m_tlast    // last_of_run
);

	qbt_result_t res0, res1, head;
	logic [1:0]  res_count;
	logic        take, room;

	assign s_tready = room;
	assign take     = s_tvalid && room;

	qbt_core #(
		.POS_BITS      (POS_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (s_tdata),
		.end_mark  (s_tuser),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	qbt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.d0         (res0),
		.d1         (res1),
		.push_count (res_count),
		.room       (room),
		.head       (head),
		.head_valid (m_tvalid),
		.pop        (m_tready)
	);

	assign m_tdata = {6'd0, head.err, head.length, head.column, head.line, head.value};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

`default_nettype wire

>>> rtl/qbt_core.sv
`default_nettype none

module qbt_core import qbt_pkg::*; #(
	parameter int POS_BITS      = POS_BITS_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_mark,
	output qbt_result_t      res0,
	output qbt_result_t      res1,
	output logic [1:0]       res_count
);

	localparam int PW = 8 * KEYWORD_CHARS;

	typedef enum logic [3:0] {
		M_IDLE, M_NUM, M_IDENT, M_SLASH, M_COMMENT,
		M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_PIPE
	} mode_t;

	mode_t               mode_q, mode_n, st_mode;
	logic [63:0]         accum_q, accum_n;
	logic                ovf_q, ovf_n;
	logic [PW-1:0]       prefix_q, prefix_n;
	logic [POS_BITS-1:0] len_q, len_n;
	logic [POS_BITS-1:0] tok_line_q, tok_line_n, tok_col_q, tok_col_n;
	logic [POS_BITS-1:0] cur_line_q, cur_line_n, cur_col_q, cur_col_n;

	logic        is_digit, is_alpha, is_space, is_word;
	logic [67:0] acc_ext, acc_sum;
	logic [5:0]  kw_kind;
	logic        fl_v, emit_fl, emit_pair, start;
	qbt_result_t fl_res, st_res, pair_res, eof_res;
	logic        st_v;
	logic [5:0]  pair_kind;
	logic [7:0]  want;

	function automatic logic [15:0] to16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic qbt_result_t mk(input logic [5:0] kind, input logic [63:0] value,
			input logic [POS_BITS-1:0] line, input logic [POS_BITS-1:0] col,
			input logic [POS_BITS-1:0] len, input logic [1:0] err);
		qbt_result_t r;
		r.kind   = kind;
		r.value  = value;
		r.line   = to16(line);
		r.column = to16(col);
		r.length = to16(len);
		r.err    = err;
		r.last   = 1'b0;
		return r;
	endfunction

	assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
	assign is_alpha = ((in_byte >= CH_UP_A) && (in_byte <= CH_UP_Z)) ||
		((in_byte >= CH_LO_A) && (in_byte <= CH_LO_Z));
	assign is_space = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
	assign is_word  = is_alpha || is_digit || (in_byte == CH_UNDER);

	assign acc_ext = {4'b0, accum_q};
	assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + 68'(in_byte - CH_0);

	always_comb begin
		kw_kind = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if ((len_q == POS_BITS'(KW_LEN[i])) && (prefix_q == PW'(KW_TEXT[i])))
				kw_kind = KW_KIND[i];
		end
	end

	always_comb begin
		fl_v   = 1'b1;
		fl_res = mk(K_ERROR, 64'd0, tok_line_q, tok_col_q, '0, E_NONE);
		unique case (mode_q)
			M_NUM: begin
				if (ovf_q)
					fl_res = mk(K_ERROR, 64'd0, tok_line_q, tok_col_q, '0, E_TOO_LARGE);
				else
					fl_res = mk(K_INT, accum_q, tok_line_q, tok_col_q, len_q, E_NONE);
			end
			M_IDENT: fl_res = mk(kw_kind, {63'd0, kw_kind == K_TRUE}, tok_line_q,
				tok_col_q, len_q, E_NONE);
			M_SLASH: fl_res = mk(K_SLASH, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			M_EQ:    fl_res = mk(K_ERROR, 64'd0, tok_line_q, tok_col_q, '0, E_EXPECT_EQ);
			M_BANG:  fl_res = mk(K_BANG, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			M_LT:    fl_res = mk(K_LT, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			M_GT:    fl_res = mk(K_GT, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			M_AMP:   fl_res = mk(K_AMP, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			M_PIPE:  fl_res = mk(K_PIPE, 64'd0, tok_line_q, tok_col_q, POS_BITS'(1), E_NONE);
			default: fl_v = 1'b0;
		endcase
	end

	always_comb begin
		want = CH_EQ;
		pair_kind = K_EQEQ;
		unique case (mode_q)
			M_BANG: pair_kind = K_NE;
			M_LT:   pair_kind = K_LE;
			M_GT:   pair_kind = K_GE;
			M_AMP: begin
				pair_kind = K_ANDAND;
				want = CH_AMP;
			end
			M_PIPE: begin
				pair_kind = K_OROR;
				want = CH_PIPE;
			end
			default: pair_kind = K_EQEQ;
		endcase
		pair_res = mk(pair_kind, 64'd0, tok_line_q, tok_col_q, POS_BITS'(2), E_NONE);
		eof_res  = mk(K_EOF, 64'd0, cur_line_q, cur_col_q, '0, E_NONE);
	end

	always_comb begin
		st_v    = 1'b1;
		st_mode = M_IDLE;
		st_res  = mk(K_ERROR, 64'd0, cur_line_q, cur_col_q, '0, E_UNEXPECTED);
		if (is_space || is_digit || is_word) begin
			st_v = 1'b0;
			if (is_digit)
				st_mode = M_NUM;
			else if (is_word)
				st_mode = M_IDENT;
		end else begin
			case (in_byte)
				CH_PLUS:   st_res = mk(K_PLUS, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_MINUS:  st_res = mk(K_MINUS, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_STAR:   st_res = mk(K_STAR, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_PCT:    st_res = mk(K_PCT, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_CARET:  st_res = mk(K_CARET, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_LPAREN: st_res = mk(K_LPAREN, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_RPAREN: st_res = mk(K_RPAREN, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_COMMA:  st_res = mk(K_COMMA, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_SEMI:   st_res = mk(K_SEMI, 64'd0, cur_line_q, cur_col_q, POS_BITS'(1), E_NONE);
				CH_SLASH: begin
					st_v = 1'b0;
					st_mode = M_SLASH;
				end
				CH_EQ: begin
					st_v = 1'b0;
					st_mode = M_EQ;
				end
				CH_BANG: begin
					st_v = 1'b0;
					st_mode = M_BANG;
				end
				CH_LT: begin
					st_v = 1'b0;
					st_mode = M_LT;
				end
				CH_GT: begin
					st_v = 1'b0;
					st_mode = M_GT;
				end
				CH_AMP: begin
					st_v = 1'b0;
					st_mode = M_AMP;
				end
				CH_PIPE: begin
					st_v = 1'b0;
					st_mode = M_PIPE;
				end
				default: st_v = 1'b1;
			endcase
		end
	end

	always_comb begin
		mode_n     = mode_q;
		accum_n    = accum_q;
		ovf_n      = ovf_q;
		prefix_n   = prefix_q;
		len_n      = len_q;
		tok_line_n = tok_line_q;
		tok_col_n  = tok_col_q;
		cur_line_n = cur_line_q;
		cur_col_n  = cur_col_q;
		emit_fl    = 1'b0;
		emit_pair  = 1'b0;
		start      = 1'b0;
		res0       = st_res;
		res1       = st_res;
		res_count  = 2'd0;
		if (end_mark) begin
			emit_fl    = fl_v;
			mode_n     = M_IDLE;
			accum_n    = 64'd0;
			ovf_n      = 1'b0;
			prefix_n   = '0;
			len_n      = '0;
			tok_line_n = POS_BITS'(1);
			tok_col_n  = POS_BITS'(1);
			cur_line_n = POS_BITS'(1);
			cur_col_n  = POS_BITS'(1);
			res0       = emit_fl ? fl_res : eof_res;
			res1       = eof_res;
			res_count  = emit_fl ? 2'd2 : 2'd1;
		end else begin
			unique case (mode_q)
				M_IDLE: start = 1'b1;
				M_NUM: begin
					if (is_digit) begin
						if (acc_sum[67:64] != 4'd0)
							ovf_n = 1'b1;
						else
							accum_n = acc_sum[63:0];
						len_n = sat_inc(len_q);
					end else begin
						emit_fl = 1'b1;
						start = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_word) begin
						for (int j = 0; j < KEYWORD_CHARS; j++) begin
							if (len_q == POS_BITS'(j))
								prefix_n[8*j +: 8] = in_byte;
						end
						len_n = sat_inc(len_q);
					end else begin
						emit_fl = 1'b1;
						start = 1'b1;
					end
				end
				M_SLASH: begin
					if (in_byte == CH_SLASH) begin
						mode_n = M_COMMENT;
					end else begin
						emit_fl = 1'b1;
						start = 1'b1;
					end
				end
				M_COMMENT: begin
					if (in_byte == CH_NL)
						mode_n = M_IDLE;
				end
				default: begin
					if (in_byte == want) begin
						emit_pair = 1'b1;
						mode_n = M_IDLE;
					end else begin
						emit_fl = 1'b1;
						start = 1'b1;
					end
				end
			endcase
			if (start) begin
				tok_line_n = cur_line_q;
				tok_col_n  = cur_col_q;
				mode_n     = st_mode;
				if (st_mode == M_NUM) begin
					accum_n = {56'd0, in_byte - CH_0};
					ovf_n   = 1'b0;
					len_n   = POS_BITS'(1);
				end else if (st_mode == M_IDENT) begin
					prefix_n = PW'(in_byte);
					len_n    = POS_BITS'(1);
				end
			end
			if (in_byte == CH_NL) begin
				cur_line_n = sat_inc(cur_line_q);
				cur_col_n  = POS_BITS'(1);
			end else begin
				cur_col_n = sat_inc(cur_col_q);
			end
			if (emit_pair) begin
				res0      = pair_res;
				res_count = 2'd1;
			end else begin
				res0      = emit_fl ? fl_res : st_res;
				res1      = st_res;
				res_count = {1'b0, emit_fl} + {1'b0, start && st_v};
			end
		end
		res0.last = (res_count == 2'd1);
		res1.last = 1'b1;
		if (!take)
			res_count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			accum_q    <= 64'd0;
			ovf_q      <= 1'b0;
			prefix_q   <= '0;
			len_q      <= '0;
			tok_line_q <= POS_BITS'(1);
			tok_col_q  <= POS_BITS'(1);
			cur_line_q <= POS_BITS'(1);
			cur_col_q  <= POS_BITS'(1);
		end else if (take) begin
			mode_q     <= mode_n;
			accum_q    <= accum_n;
			ovf_q      <= ovf_n;
			prefix_q   <= prefix_n;
			len_q      <= len_n;
			tok_line_q <= tok_line_n;
			tok_col_q  <= tok_col_n;
			cur_line_q <= cur_line_n;
			cur_col_q  <= cur_col_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/qbt_outq.sv
`default_nettype none

module qbt_outq import qbt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire qbt_result_t d0,
	input  wire qbt_result_t d1,
	input  wire logic [1:0]  push_count,
	output logic             room,
	output qbt_result_t      head,
	output logic             head_valid,
	input  wire logic        pop
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	qbt_result_t   mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q, wr_next;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign wr_next    = wr_q + 1'b1;
	assign head       = mem_q[rd_q];
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign room       = (count_q <= CW'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0)
			mem_q[wr_q] <= d0;
		if (push_count == 2'd2)
			mem_q[wr_next] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(push_count);
			rd_q    <= rd_q + AW'(do_pop);
			count_q <= count_q + CW'(push_count) - CW'(do_pop);
		end
	end

endmodule

`default_nettype wire
